FILE: rtl/assert_macros.svh
// Assertion helpers for the resonator bank RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define ASSERT_CLK(lbl, prop, msg) `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/mrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrb_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int HIST_W     = 24;
  localparam int MODE_IDX_W = 5;
  localparam int ACTION_W   = 2;
  localparam int SEL_W      = 2;
  localparam int WET_W      = 17;
  localparam int TRIM_W     = 16;
  localparam int CFG_IDX_W  = 1;

  // Shared multiplier operands and the accumulator.
  localparam int OPA_W  = 31;
  localparam int OPB_W  = 25;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = 64;

  // The mix value is split into a low unsigned part and a high signed part.
  localparam int HI_SPLIT = 24;
  localparam int MIX_HI_W = 24;

  localparam int MIX_SHIFT = 5;
  localparam int HIST_RND  = 16;
  localparam int OUT_RND   = 33;

  localparam logic [WET_W-1:0]    FULL_MIX   = 17'd65536;
  localparam logic [WET_W-1:0]    WET_RESET  = 17'd65536;
  localparam logic [TRIM_W-1:0]   TRIM_RESET = 16'd4096;
  localparam logic [HIST_W-1:0]   HIST_MAX   = 24'h7FFFFF;
  localparam logic [HIST_W-1:0]   HIST_MIN   = 24'h800000;
  localparam logic [SAMPLE_W-1:0] OUT_MAX    = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] OUT_MIN    = 16'h8000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_COEF   = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  localparam logic [SEL_W-1:0] SEL_A1   = 2'd0;
  localparam logic [SEL_W-1:0] SEL_A2   = 2'd1;
  localparam logic [SEL_W-1:0] SEL_GAIN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM    = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/mrb_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mrb_in_if import mrb_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [ACTION_W-1:0]         action;
  logic signed [SAMPLE_W-1:0]  sample_in;
  logic [MODE_IDX_W-1:0]       mode_index;
  logic [SEL_W-1:0]            coef_select;
  logic signed [COEF_W-1:0]    coef_value;

  modport source (
    output valid, action, sample_in, mode_index, coef_select, coef_value,
    input  ready
  );
  modport sink (
    input  valid, action, sample_in, mode_index, coef_select, coef_value,
    output ready
  );
endinterface

interface mrb_out_if import mrb_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_W-1:0]  sample_out;

  modport source (
    output valid, sample_out,
    input  ready
  );
  modport sink (
    input  valid, sample_out,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/mrb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mrb_ram #(
  parameter int W     = 18,
  parameter int DEPTH = 96
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [W-1:0]                              wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [W-1:0]                              rdata_o
);

  logic [W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/modal_resonator_bank.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Channel    Role    Payload
// item_i     sink    action, sample_in, mode_index, coef_select, coef_value
// result_o   source  sample_out
// cfg        write   cfg_we_i, cfg_idx_i, cfg_data_i (wet_mix, output_trim)
//
// A coefficient write or history clear item is completed as it is taken.
// A sample item passes S_RDG, S_MG for each mode, S_M1, S_M2, S_WB for an
// active mode, then S_X0 to S_X3, S_OUT: one multiply-accumulate unit forms
// three products per mode and the coefficient RAM gives one word per cycle.
// Reset clears valid bits for every coefficient and history entry at once;
// there is no clearing pass. A waiting result sits in the output register
// while the next item is taken; only the final output step waits on it.

module modal_resonator_bank
  import mrb_pkg::*;
#(
  parameter int MODES = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  mrb_in_if.sink                     item_i,
  mrb_out_if.source                  result_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [WET_W-1:0]      cfg_data_i
);

  localparam int NCOEF = 3 * MODES;
  localparam int CA_W  = $clog2(NCOEF);
  localparam int MI_W  = (MODES > 1) ? $clog2(MODES) : 1;
  localparam int SUM_W = HIST_W + $clog2(MODES);
  localparam logic [MI_W-1:0] LAST_MODE = MI_W'(MODES - 1);
  localparam logic signed [ACC_W-1:0] HIST_HALF = ACC_W'(1) << (HIST_RND - 1);
  localparam logic signed [ACC_W-1:0] OUT_HALF  = ACC_W'(1) << (OUT_RND - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDG,
    S_MG,
    S_M1,
    S_M2,
    S_WB,
    S_X0,
    S_X1,
    S_X2,
    S_X3,
    S_OUT
  } state_e;

  state_e                     state_q, state_d;
  logic [MI_W-1:0]            mode_q, mode_d;
  logic [CA_W-1:0]            base_q, base_d;
  logic [MODES-1:0]           hist_vld_q, hist_vld_d;
  logic [NCOEF-1:0]           coef_vld_q, coef_vld_d;
  logic                       coef_rvld_q, coef_rvld_d;
  logic                       hist_rvld_q, hist_rvld_d;
  logic [WET_W-1:0]           wet_q, wet_d;
  logic [TRIM_W-1:0]          trim_q, trim_d;
  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] out_data_q, out_data_d;

  logic signed [SAMPLE_W-1:0] x_q, x_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [HIST_W-1:0]   y1_q, y1_d, y2_q, y2_d;
  logic signed [MIX_HI_W-1:0] mh_q, mh_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;

  logic                       coef_we;
  logic [CA_W-1:0]            coef_waddr, coef_raddr;
  logic [COEF_W-1:0]          coef_rdata;
  logic                       hist_we;
  logic [MI_W-1:0]            hist_raddr;
  logic [2*HIST_W-1:0]        hist_wdata, hist_rdata;

  logic                       in_acc;
  logic                       coef_ok;
  logic [6:0]                 coef_lin;
  logic signed [COEF_W-1:0]   coef_word;
  logic [WET_W-1:0]           mix_m, dry_m;
  logic signed [OPA_W-1:0]    op_a;
  logic signed [OPB_W-1:0]    op_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    hist_sh, out_sh;
  logic                       hist_fit, out_fit;
  logic signed [HIST_W-1:0]   y_sat;
  logic signed [SAMPLE_W-1:0] out_sat;

  assign in_acc         = item_i.valid && item_i.ready;
  assign item_i.ready   = (state_q == S_IDLE);
  assign result_o.valid = out_valid_q;
  assign result_o.sample_out = out_data_q;

  // Coefficient writes beyond the bank or with the unused select are dropped.
  assign coef_ok = (int'(item_i.mode_index) < MODES) &&
                   ((item_i.coef_select == SEL_A1) || (item_i.coef_select == SEL_A2) ||
                    (item_i.coef_select == SEL_GAIN));
  assign coef_lin   = 7'(item_i.mode_index) * 7'd3 + 7'(item_i.coef_select);
  assign coef_waddr = CA_W'(coef_lin);

  // Entries never written since reset read as zero.
  assign coef_word = coef_rvld_q ? $signed(coef_rdata) : '0;

  assign mix_m = (wet_q > FULL_MIX) ? FULL_MIX : wet_q;
  assign dry_m = FULL_MIX - mix_m;

  // Shared multiplier.
  assign prod     = op_a * op_b;
  assign prod_ext = ACC_W'(prod);

  assign hist_sh  = (acc_q + HIST_HALF) >>> HIST_RND;
  assign hist_fit = (&hist_sh[ACC_W-1:HIST_W-1]) | ~(|hist_sh[ACC_W-1:HIST_W-1]);
  assign y_sat    = hist_fit ? hist_sh[HIST_W-1:0]
                             : (hist_sh[ACC_W-1] ? HIST_MIN : HIST_MAX);

  assign out_sh  = (acc_q + OUT_HALF) >>> OUT_RND;
  assign out_fit = (&out_sh[ACC_W-1:SAMPLE_W-1]) | ~(|out_sh[ACC_W-1:SAMPLE_W-1]);
  assign out_sat = out_fit ? out_sh[SAMPLE_W-1:0]
                           : (out_sh[ACC_W-1] ? OUT_MIN : OUT_MAX);

  assign hist_wdata = {y_sat, y1_q};

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    base_d      = base_q;
    hist_vld_d  = hist_vld_q;
    coef_vld_d  = coef_vld_q;
    wet_d       = wet_q;
    trim_d      = trim_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    x_d         = x_q;
    acc_d       = acc_q;
    y1_d        = y1_q;
    y2_d        = y2_q;
    mh_d        = mh_q;
    sum_d       = sum_q;
    coef_we     = 1'b0;
    hist_we     = 1'b0;
    coef_raddr  = base_q;
    hist_raddr  = mode_q;
    op_a        = OPA_W'(x_q);
    op_b        = '0;

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WET_MIX: wet_d  = cfg_data_i;
        CFG_TRIM:    trim_d = cfg_data_i[TRIM_W-1:0];
        default:     ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (item_i.action)
            ACT_SAMPLE: begin
              x_d     = item_i.sample_in;
              sum_d   = '0;
              mode_d  = '0;
              base_d  = '0;
              state_d = S_RDG;
            end
            ACT_COEF: begin
              if (coef_ok) begin
                coef_we                = 1'b1;
                coef_vld_d[coef_waddr] = 1'b1;
              end
            end
            ACT_CLEAR: begin
              hist_vld_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_RDG: begin
        coef_raddr = base_q + CA_W'(2);
        state_d    = S_MG;
      end
      S_MG: begin
        // Gain word and history are here; a zero gain skips the mode.
        y1_d  = hist_rvld_q ? $signed(hist_rdata[2*HIST_W-1:HIST_W]) : '0;
        y2_d  = hist_rvld_q ? $signed(hist_rdata[HIST_W-1:0]) : '0;
        op_b  = OPB_W'(coef_word);
        acc_d = prod_ext <<< MIX_SHIFT;
        if (coef_word == '0) begin
          if (mode_q == LAST_MODE) begin
            state_d = S_X0;
          end else begin
            mode_d  = mode_q + MI_W'(1);
            base_d  = base_q + CA_W'(3);
            state_d = S_RDG;
          end
        end else begin
          state_d = S_M1;
        end
      end
      S_M1: begin
        coef_raddr = base_q + CA_W'(1);
        op_a       = OPA_W'(y1_q);
        op_b       = OPB_W'(coef_word);
        acc_d      = acc_q + prod_ext;
        state_d    = S_M2;
      end
      S_M2: begin
        op_a    = OPA_W'(y2_q);
        op_b    = OPB_W'(coef_word);
        acc_d   = acc_q + prod_ext;
        state_d = S_WB;
      end
      S_WB: begin
        hist_we            = 1'b1;
        hist_vld_d[mode_q] = 1'b1;
        sum_d              = sum_q + SUM_W'(y_sat);
        if (mode_q == LAST_MODE) begin
          state_d = S_X0;
        end else begin
          mode_d  = mode_q + MI_W'(1);
          base_d  = base_q + CA_W'(3);
          state_d = S_RDG;
        end
      end
      S_X0: begin
        op_b    = $signed(OPB_W'(dry_m));
        acc_d   = prod_ext <<< MIX_SHIFT;
        state_d = S_X1;
      end
      S_X1: begin
        op_a    = OPA_W'(sum_q);
        op_b    = $signed(OPB_W'(mix_m));
        acc_d   = acc_q + prod_ext;
        state_d = S_X2;
      end
      S_X2: begin
        // The trim product is built from two partial products.
        mh_d    = acc_q[HI_SPLIT+MIX_HI_W-1:HI_SPLIT];
        op_a    = $signed(OPA_W'(acc_q[HI_SPLIT-1:0]));
        op_b    = $signed(OPB_W'(trim_q));
        acc_d   = prod_ext;
        state_d = S_X3;
      end
      S_X3: begin
        op_a    = OPA_W'(mh_q);
        op_b    = $signed(OPB_W'(trim_q));
        acc_d   = acc_q + (prod_ext <<< HI_SPLIT);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = out_sat;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    coef_rvld_d = coef_vld_q[coef_raddr];
    hist_rvld_d = hist_vld_q[hist_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= '0;
      base_q      <= '0;
      hist_vld_q  <= '0;
      coef_vld_q  <= '0;
      coef_rvld_q <= 1'b0;
      hist_rvld_q <= 1'b0;
      wet_q       <= WET_RESET;
      trim_q      <= TRIM_RESET;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      base_q      <= base_d;
      hist_vld_q  <= hist_vld_d;
      coef_vld_q  <= coef_vld_d;
      coef_rvld_q <= coef_rvld_d;
      hist_rvld_q <= hist_rvld_d;
      wet_q       <= wet_d;
      trim_q      <= trim_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    acc_q <= acc_d;
    y1_q  <= y1_d;
    y2_q  <= y2_d;
    mh_q  <= mh_d;
    sum_q <= sum_d;
  end

  mrb_ram #(
    .W     (COEF_W),
    .DEPTH (NCOEF)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (item_i.coef_value),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  // Each entry holds the newest history word above the older one.
  mrb_ram #(
    .W     (2 * HIST_W),
    .DEPTH (MODES)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (mode_q),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  `ASSERT_CLK(a_result_from_out_step, $rose(out_valid_q) |-> $past(state_q) == S_OUT, "result raised outside the output step")
  `ASSERT_CLK(a_clear_empties_hist, (in_acc && item_i.action == ACT_CLEAR) |=> (hist_vld_q == '0), "history clear left valid entries")
  `ASSERT_CLK(a_mode_in_range, int'(mode_q) < MODES, "mode counter beyond the bank")

endmodule

`default_nettype wire

FILE: test/tb_modal_resonator_bank.sv
`timescale 1ns / 1ps

module tb_modal_resonator_bank;
  import mrb_pkg::*;

  localparam int MODE_COUNT = 32;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [SEL_W-1:0]    SEL_UNUSED = 2'd3;
  localparam int GAP_MAX       = 18;
  localparam int LONG_HOLD     = 1200;
  localparam int HOLD_AFTER    = 150;
  localparam int QUIET_LIMIT   = 6000;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 200;
  localparam int RANDOM_ITEMS  = 1100;

  typedef struct {
    logic [ACTION_W-1:0]        action;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [MODE_IDX_W-1:0]      mode_index;
    logic [SEL_W-1:0]           coef_select;
    logic signed [COEF_W-1:0]   coef_value;
  } bank_item_t;

  typedef struct {
    bank_item_t                 item;
    bit                         known;
    logic signed [SAMPLE_W-1:0] known_out;
  } directed_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [WET_W-1:0]     cfg_data_i;

  mrb_in_if  in_if ();
  mrb_out_if out_if ();

  modal_resonator_bank #(
    .MODES(MODE_COUNT)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (in_if),
    .result_o  (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the bank: coefficient words, both histories and the registers.
  logic signed [COEF_W-1:0] coef_words [3*MODE_COUNT];
  logic signed [HIST_W-1:0] hist_one [MODE_COUNT];
  logic signed [HIST_W-1:0] hist_two [MODE_COUNT];
  logic [WET_W-1:0]         wet_share;
  logic [TRIM_W-1:0]        trim_gain;

  logic signed [SAMPLE_W-1:0] expected_samples [$];

  int mismatches;
  int samples_checked;
  int sample_items;
  int coef_items;
  int clear_items;
  int settings_used;
  int quiet_cycles;
  bit steady_send;

  directed_row_t directed_rows [24] = '{
    '{'{ACT_SAMPLE, 16'sh7FFF, 5'd0,  SEL_A1,     18'sd0},     1'b1, 16'sd0},
    '{'{ACT_SAMPLE, 16'sh8000, 5'd31, SEL_GAIN,   18'sh1FFFF}, 1'b1, 16'sd0},
    '{'{ACT_UNUSED, 16'sh7FFF, 5'd31, SEL_GAIN,   18'sh1FFFF}, 1'b0, 16'sd0},
    '{'{ACT_CLEAR,  16'sh0000, 5'd0,  SEL_A1,     18'sd0},     1'b0, 16'sd0},
    '{'{ACT_SAMPLE, 16'sh0000, 5'd0,  SEL_A1,     18'sd0},     1'b1, 16'sd0},
    '{'{ACT_COEF,   16'sh0000, 5'd0,  SEL_GAIN,   18'sh1FFFF}, 1'b0, 16'sd0},
    '{'{ACT_COEF,   16'sh0000, 5'd0,  SEL_A1,     18'sh20000}, 1'b0, 16'sd0},
    '{'{ACT_COEF,   16'sh0000, 5'd0,  SEL_A2,     18'sh1FFFF}, 1'b0, 16'sd0},
    '{'{ACT_COEF,   16'sh0000, 5'd0,  SEL_UNUSED, -18'sd1},    1'b0, 16'sd0},
    '{'{ACT_COEF,   16'sh0000, 5'd31, SEL_GAIN,   18'sh20000}, 1'b0, 16'sd0},
    '{'{ACT_COEF,   16'sh0000, 5'd31, SEL_A1,     18'sd65536}, 1'b0, 16'sd0},
    '{'{ACT_COEF,   16'sh0000, 5'd31, SEL_A2,     -18'sd65536},1'b0, 16'sd0},
    '{'{ACT_SAMPLE, 16'sh7FFF, 5'd0,  SEL_A1,     18'sd0},     1'b0, 16'sd0},
    '{'{ACT_SAMPLE, 16'sh8000, 5'd0,  SEL_A1,     18'sd0},     1'b0, 16'sd0},
    '{'{ACT_SAMPLE, 16'sh7FFF, 5'd0,  SEL_A1,     18'sd0},     1'b0, 16'sd0},
    '{'{ACT_SAMPLE, 16'sh0000, 5'd0,  SEL_A1,     18'sd0},     1'b0, 16'sd0},
    '{'{ACT_CLEAR,  16'sh7FFF, 5'd31, SEL_UNUSED, 18'sh1FFFF}, 1'b0, 16'sd0},
    '{'{ACT_SAMPLE, 16'sh0001, 5'd0,  SEL_A1,     18'sd0},     1'b0, 16'sd0},
    '{'{ACT_SAMPLE, -16'sd1,   5'd0,  SEL_A1,     18'sd0},     1'b0, 16'sd0},
    '{'{ACT_COEF,   16'sh0000, 5'd0,  SEL_GAIN,   18'sd0},     1'b0, 16'sd0},
    '{'{ACT_SAMPLE, 16'sh8000, 5'd0,  SEL_A1,     18'sd0},     1'b0, 16'sd0},
    '{'{ACT_COEF,   16'sh0000, 5'd31, SEL_GAIN,   18'sd0},     1'b0, 16'sd0},
    '{'{ACT_SAMPLE, 16'sh7FFF, 5'd0,  SEL_A1,     18'sd0},     1'b1, 16'sd0},
    '{'{ACT_UNUSED, 16'sh8000, 5'd0,  SEL_A1,     18'sh20000}, 1'b0, 16'sd0}
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint round_half_up(longint v, int shift);
    return (v + (longint'(1) << (shift - 1))) >>> shift;
  endfunction

  // Runs one sample through every voiced mode and forms the mixed, trimmed output.
  function automatic logic signed [SAMPLE_W-1:0] bank_output(logic signed [SAMPLE_W-1:0] x);
    longint xs;
    longint acc;
    longint y;
    longint sum;
    longint m;
    longint mixv;
    longint res;
    int k;
    xs = longint'(x);
    sum = 0;
    for (k = 0; k < MODE_COUNT; k++) begin
      if (coef_words[3*k+2] != 0) begin
        acc = longint'(coef_words[3*k]) * longint'(hist_one[k])
            + longint'(coef_words[3*k+1]) * longint'(hist_two[k])
            + longint'(coef_words[3*k+2]) * xs * (longint'(1) << MIX_SHIFT);
        y = round_half_up(acc, HIST_RND);
        if (y > longint'($signed(HIST_MAX))) y = longint'($signed(HIST_MAX));
        if (y < longint'($signed(HIST_MIN))) y = longint'($signed(HIST_MIN));
        hist_two[k] = hist_one[k];
        hist_one[k] = y[HIST_W-1:0];
        sum += y;
      end
    end
    m = (wet_share > FULL_MIX) ? longint'(FULL_MIX) : longint'(wet_share);
    mixv = xs * (longint'(1) << MIX_SHIFT) * (longint'(FULL_MIX) - m) + sum * m;
    res = round_half_up(mixv * longint'(trim_gain), OUT_RND);
    if (res > longint'($signed(OUT_MAX))) res = longint'($signed(OUT_MAX));
    if (res < longint'($signed(OUT_MIN))) res = longint'($signed(OUT_MIN));
    return res[SAMPLE_W-1:0];
  endfunction

  function automatic bank_item_t random_item();
    bank_item_t it;
    it.action      = ACT_SAMPLE;
    it.sample_in   = SAMPLE_W'($urandom);
    it.mode_index  = MODE_IDX_W'($urandom);
    it.coef_select = SEL_W'($urandom);
    it.coef_value  = COEF_W'($urandom);
    return it;
  endfunction

  task automatic report_mismatch(string what, logic signed [SAMPLE_W-1:0] got,
                                 logic signed [SAMPLE_W-1:0] want);
    $display("MISMATCH at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offers one item and, once it is taken, advances the shadow bank.
  task automatic offer_item(bank_item_t it, bit known, logic signed [SAMPLE_W-1:0] known_out);
    int gap;
    logic signed [SAMPLE_W-1:0] predicted;
    int k;
    gap = steady_send ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.action      <= it.action;
    in_if.sample_in   <= it.sample_in;
    in_if.mode_index  <= it.mode_index;
    in_if.coef_select <= it.coef_select;
    in_if.coef_value  <= it.coef_value;
    do @(posedge clk_i); while (!in_if.ready);
    case (it.action)
      ACT_SAMPLE: begin
        predicted = bank_output(it.sample_in);
        expected_samples.push_back(known ? known_out : predicted);
        sample_items++;
      end
      ACT_COEF: begin
        if (it.coef_select != SEL_UNUSED)
          coef_words[3*it.mode_index + it.coef_select] = it.coef_value;
        coef_items++;
      end
      ACT_CLEAR: begin
        for (k = 0; k < MODE_COUNT; k++) begin
          hist_one[k] = '0;
          hist_two[k] = '0;
        end
        clear_items++;
      end
      default: ;
    endcase
  endtask

  // Stops offering and waits until every sample item has produced its output.
  task automatic settle_block(int cycles);
    in_if.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [WET_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WET_MIX) wet_share = data;
    else trim_gain = data[TRIM_W-1:0];
    settings_used++;
    @(posedge clk_i);
  endtask

  task automatic program_mode();
    bank_item_t it;
    int r2;
    int mode;
    bit wild;
    mode = $urandom_range(0, MODE_COUNT - 1);
    wild = ($urandom_range(0, 7) == 0);
    r2 = $urandom_range(50000, 65535);
    it = random_item();
    it.action = ACT_COEF;
    it.mode_index = MODE_IDX_W'(mode);
    // A stable pole pair needs a1 squared below four times -a2.
    it.coef_select = SEL_A1;
    if (!wild) it.coef_value = COEF_W'(int'($urandom_range(0, 220000)) - 110000);
    offer_item(it, 1'b0, '0);
    it.coef_select = SEL_A2;
    if (!wild) it.coef_value = COEF_W'(-r2);
    offer_item(it, 1'b0, '0);
    it.coef_select = SEL_GAIN;
    if (!wild && $urandom_range(0, 6) != 0)
      it.coef_value = COEF_W'(int'($urandom_range(0, 40000)) - 20000);
    if (it.coef_value == 0) it.coef_value = COEF_W'(1);
    offer_item(it, 1'b0, '0);
  endtask

  // One phase: new register settings, a mostly well-formed setup, then samples with noise.
  task automatic run_phase(output int counted);
    bank_item_t it;
    logic [WET_W-1:0] wet;
    logic [TRIM_W-1:0] trim;
    int r;
    int n;
    counted = 0;
    settle_block(SETTLE_CYCLES);
    case ($urandom_range(0, 4))
      0: wet = '0;
      1: wet = FULL_MIX;
      2: wet = '1;
      3: wet = WET_W'($urandom_range(0, 65536));
      default: wet = WET_W'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: trim = '0;
      1: trim = TRIM_RESET;
      2: trim = '1;
      default: trim = TRIM_W'($urandom);
    endcase
    if ($urandom_range(0, 6) != 0) write_register(CFG_WET_MIX, wet);
    if ($urandom_range(0, 6) != 0) write_register(CFG_TRIM, {1'($urandom), trim});
    steady_send = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 4) != 0) begin
      it = random_item();
      it.action = ACT_CLEAR;
      offer_item(it, 1'b0, '0);
      counted++;
    end
    repeat ($urandom_range(1, 4)) begin
      program_mode();
      counted += 3;
    end
    n = $urandom_range(40, 90);
    repeat (n) begin
      it = random_item();
      r = $urandom_range(0, 99);
      if (r < 80) begin
        if ($urandom_range(0, 9) == 0)
          it.sample_in = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        counted++;
      end else if (r < 86) begin
        it.action = ACT_COEF;
        if (it.coef_select != SEL_UNUSED) counted++;
      end else if (r < 90) begin
        it.action = ACT_CLEAR;
        counted++;
      end else if (r < 94) begin
        it.action = ACT_UNUSED;
      end else begin
        it.action = ACT_COEF;
        it.coef_select = SEL_GAIN;
        it.coef_value = '0;
        counted++;
      end
      offer_item(it, 1'b0, '0);
    end
  endtask

  // Output side: random stalls, calm stretches, and one long hold-off.
  initial begin : result_sink
    int gap;
    int run_left;
    bit steady_take;
    bit held_long;
    logic signed [SAMPLE_W-1:0] want;
    out_if.ready = 1'b0;
    run_left = 0;
    steady_take = 1'b0;
    held_long = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (run_left == 0) begin
        steady_take = ($urandom_range(0, 4) == 0);
        run_left = $urandom_range(10, 40);
      end else begin
        run_left--;
      end
      gap = steady_take ? 0 : $urandom_range(0, GAP_MAX);
      if (!held_long && samples_checked >= HOLD_AFTER) begin
        gap = LONG_HOLD;
        held_long = 1'b1;
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      if (expected_samples.size() == 0) begin
        report_mismatch("output item with none expected", out_if.sample_out, '0);
      end else begin
        want = expected_samples.pop_front();
        if (out_if.sample_out !== want) report_mismatch("sample_out", out_if.sample_out, want);
      end
      samples_checked++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("No handshake for %0d cycles, %0d output items outstanding",
               QUIET_LIMIT, expected_samples.size());
      $display("tb_modal_resonator_bank NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int k;
    int random_done;
    int counted;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_WET_MIX;
    cfg_data_i        = '0;
    in_if.valid       = 1'b0;
    in_if.action      = ACT_SAMPLE;
    in_if.sample_in   = '0;
    in_if.mode_index  = '0;
    in_if.coef_select = SEL_A1;
    in_if.coef_value  = '0;
    quiet_cycles      = 0;
    steady_send       = 1'b0;
    for (k = 0; k < 3*MODE_COUNT; k++) coef_words[k] = '0;
    for (k = 0; k < MODE_COUNT; k++) begin
      hist_one[k] = '0;
      hist_two[k] = '0;
    end
    wet_share = WET_RESET;
    trim_gain = TRIM_RESET;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r])
      offer_item(directed_rows[r].item, directed_rows[r].known, directed_rows[r].known_out);

    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      run_phase(counted);
      random_done += counted;
    end

    settle_block(DRAIN_CYCLES);
    $display("Ran %0d sample, %0d coefficient and %0d clear items under %0d register writes.",
             sample_items, coef_items, clear_items, settings_used);
    $display("Checked %0d output items with %0d mismatches.", samples_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_modal_resonator_bank OK");
    end else begin
      $display("tb_modal_resonator_bank NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mrb_pkg.sv
rtl/mrb_if.sv
rtl/mrb_ram.sv
rtl/modal_resonator_bank.sv
test/tb_modal_resonator_bank.sv
